// ===== rtl/core/pclr_pkg.sv =====
// Shared types, constants and codes of the packed cell line resampler.
`timescale 1ns / 1ps

package pclr_pkg;

  // Line store geometry.
  localparam int LINE_BYTES    = 1024;
  localparam int BYTE_W        = 8;
  localparam int ADDR_W        = $clog2(LINE_BYTES);
  localparam int LINE_BITS_W   = ADDR_W + 3;

  // Cell and register field widths.
  localparam int MAX_CELL_BITS = 32;
  localparam int CELL_BITS_W   = 6;
  localparam int BIT_CNT_W     = $clog2(MAX_CELL_BITS);
  localparam int START_W       = 13;
  localparam int WIDTH_W       = 14;
  localparam int LEN_W         = 11;
  localparam int CELL_POS_W    = WIDTH_W + 1;
  localparam int PROD_W        = CELL_POS_W + CELL_BITS_W;

  // Channel and configuration port widths.
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = WIDTH_W;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CELL_BITS,
    REG_SRC_START,
    REG_SRC_WIDTH,
    REG_DST_START,
    REG_DST_WIDTH,
    REG_SRC_LEN,
    REG_DST_LEN
  } reg_index_t;

  // Operation codes of an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SRC,
    OP_LOAD_DST,
    OP_RUN,
    OP_READ_DST
  } op_t;

  // Status codes of a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_SRC_RANGE,
    STATUS_DST_RANGE
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_SRC,
    ST_CMP_SRC,
    ST_MUL_DST,
    ST_CMP_DST,
    ST_DIV,
    ST_CELL,
    ST_BIT_RD,
    ST_BIT_WR
  } state_t;

  // One result item as held in the output stages.
  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    status_t           status;
  } result_t;

  // Answer of the serial divider.
  typedef struct packed {
    logic               done;
    logic [WIDTH_W-1:0] quotient;
    logic [WIDTH_W-1:0] remainder;
  } div_res_t;

endpackage

// ===== rtl/core/pclr_req_if.sv =====
// Input channel of the resampler: operation, byte address and byte data.
`timescale 1ns / 1ps

interface pclr_req_if;
  import pclr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0] byte_data;

  modport source (output valid, output operation, output byte_address, output byte_data,
                  input ready);
  modport sink   (input valid, input operation, input byte_address, input byte_data,
                  output ready);
endinterface

// ===== rtl/core/pclr_res_if.sv =====
// Result channel of the resampler: read data and status.
`timescale 1ns / 1ps

interface pclr_res_if;
  import pclr_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink   (input valid, input read_data, input status, output ready);
endinterface

// ===== rtl/core/pclr_div.sv =====
// Bit-serial restoring divider that produces the source step per destination cell.
`timescale 1ns / 1ps

module pclr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pclr_pkg::WIDTH_W-1:0]      dividend,
  input  logic [pclr_pkg::WIDTH_W-1:0]      divisor,
  output pclr_pkg::div_res_t                res
);
  import pclr_pkg::*;

  localparam int CNT_W = $clog2(WIDTH_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WIDTH_W - 1);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [WIDTH_W-1:0] num;
  logic [WIDTH_W-1:0] rem;
  logic [WIDTH_W-1:0] dsor;
  logic [WIDTH_W:0]   trial;
  logic [WIDTH_W:0]   diff;
  logic               ge;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial = {rem, num[WIDTH_W-1]};
  assign diff  = trial - {1'b0, dsor};
  assign ge    = trial >= {1'b0, dsor};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      num <= {num[WIDTH_W-2:0], ge};
    end
  end

  assign res.done      = done;
  assign res.quotient  = num;
  assign res.remainder = rem;

endmodule

// ===== rtl/core/packed_cell_line_resampler.sv =====
// Top level of the packed cell line resampler: line stores, sequencer and result stages.
`timescale 1ns / 1ps

// The block holds a source line and a destination line of 1024 bytes each, with
// pixel cells packed MSB first. Load and read transactions address single bytes;
// a load is done in the idle state and a read passes through ST_READ, and both line
// stores start undefined, so every byte must be loaded before it is used. A run
// transaction checks both lines against their configured byte lengths (32-bit
// aligned), divides src_width by dst_width in a 14-step serial divider, then copies
// every destination cell from the source cell that its position maps to (rounded
// down), one bit at a time, each bit a read-modify-write on the byte-wide stores
// in ST_BIT_RD and ST_BIT_WR. A failed source check ends the run in ST_CMP_SRC
// and a failed destination check in ST_CMP_DST, and both pass through the result
// stages. Every transaction returns exactly one result, and a finished result waits
// in a two-stage output queue so the next transaction can start.
// Configuration registers may be written only while no transaction is pending.
module packed_cell_line_resampler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pclr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pclr_pkg::CFG_DATA_W-1:0]   cfg_data,
  pclr_req_if.sink                          request,
  pclr_res_if.source                        result
);
  import pclr_pkg::*;

  localparam int ALIGN_W = PROD_W - 2;

  // Configuration registers.
  logic [CELL_BITS_W-1:0] cell_bits;
  logic [START_W-1:0]     src_start;
  logic [WIDTH_W-1:0]     src_width;
  logic [START_W-1:0]     dst_start;
  logic [WIDTH_W-1:0]     dst_width;
  logic [LEN_W-1:0]       src_len_bytes;
  logic [LEN_W-1:0]       dst_len_bytes;

  // Effective values after clamping.
  logic [CELL_BITS_W-1:0] bits_eff;
  logic [WIDTH_W-1:0]     sw_eff;
  logic [LEN_W-1:0]       src_len_eff;
  logic [LEN_W-1:0]       dst_len_eff;
  logic [LEN_W-1:0]       len_sel;

  // Sequencer and datapath.
  state_t                 state;
  state_t                 state_next;
  logic                   req_ready;
  logic [CELL_POS_W-1:0]  mul_a;
  logic [PROD_W-1:0]      mul_p;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W:0]        prod_round;
  logic [ALIGN_W-1:0]     aligned_bytes;
  logic                   range_fail;
  logic                   div_start;
  div_res_t               div_res;
  logic [WIDTH_W-1:0]     q_step;
  logic [WIDTH_W-1:0]     r_step;
  logic [WIDTH_W-1:0]     racc;
  logic [WIDTH_W:0]       racc_sum;
  logic                   racc_wrap;
  logic [CELL_POS_W-1:0]  scell;
  logic [WIDTH_W-1:0]     cell_cnt;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [LINE_BITS_W-1:0] spos;
  logic [LINE_BITS_W-1:0] dpos;
  logic                   bit_last;
  logic                   cell_last;

  // Line stores.
  logic [BYTE_W-1:0]      src_mem [LINE_BYTES];
  logic [BYTE_W-1:0]      dst_mem [LINE_BYTES];
  logic [BYTE_W-1:0]      src_q;
  logic [BYTE_W-1:0]      dst_q;
  logic                   src_we;
  logic                   dst_we;
  logic [ADDR_W-1:0]      src_raddr;
  logic [ADDR_W-1:0]      dst_raddr;
  logic [ADDR_W-1:0]      dst_waddr;
  logic [BYTE_W-1:0]      dst_wdata;
  logic [BYTE_W-1:0]      merged;

  // Result stages: a hold slot in front of the output register.
  logic                   hold_valid;
  result_t                hold_data;
  logic                   hold_load;
  result_t                hold_value;
  logic                   hold_move;
  logic                   out_valid;
  result_t                out_data;
  logic                   out_free;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_bits     <= CELL_BITS_W'(1);
      src_start     <= '0;
      src_width     <= WIDTH_W'(1);
      dst_start     <= '0;
      dst_width     <= WIDTH_W'(1);
      src_len_bytes <= LEN_W'(LINE_BYTES);
      dst_len_bytes <= LEN_W'(LINE_BYTES);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CELL_BITS: cell_bits     <= cfg_data[CELL_BITS_W-1:0];
        REG_SRC_START: src_start     <= cfg_data[START_W-1:0];
        REG_SRC_WIDTH: src_width     <= cfg_data[WIDTH_W-1:0];
        REG_DST_START: dst_start     <= cfg_data[START_W-1:0];
        REG_DST_WIDTH: dst_width     <= cfg_data[WIDTH_W-1:0];
        REG_SRC_LEN:   src_len_bytes <= cfg_data[LEN_W-1:0];
        REG_DST_LEN:   dst_len_bytes <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the cell width, the source width and both line lengths.
  assign bits_eff    = (cell_bits > CELL_BITS_W'(MAX_CELL_BITS)) ?
                       CELL_BITS_W'(MAX_CELL_BITS) : cell_bits;
  assign sw_eff      = (src_width == '0) ? WIDTH_W'(1) : src_width;
  assign src_len_eff = (src_len_bytes > LEN_W'(LINE_BYTES)) ?
                       LEN_W'(LINE_BYTES) : src_len_bytes;
  assign dst_len_eff = (dst_len_bytes > LEN_W'(LINE_BYTES)) ?
                       LEN_W'(LINE_BYTES) : dst_len_bytes;

  // The one shared multiplier: cell count or cell index times cell width.
  assign mul_p = PROD_W'(mul_a) * PROD_W'(bits_eff);

  // Line length in bytes, rounded up to whole 32-bit words, against the configured line length.
  assign prod_round    = {1'b0, prod} + (PROD_W + 1)'(31);
  assign aligned_bytes = {prod_round[PROD_W:5], 2'b00};
  assign len_sel       = (state == ST_CMP_SRC) ? src_len_eff : dst_len_eff;
  assign range_fail    = aligned_bytes > ALIGN_W'(len_sel);

  // Cell and bit progress.
  assign bit_last  = bit_cnt == BIT_CNT_W'(bits_eff - 1'b1);
  assign cell_last = WIDTH_W'(cell_cnt + 1'b1) == dst_width;
  assign racc_sum  = (WIDTH_W + 1)'(racc) + (WIDTH_W + 1)'(r_step);
  assign racc_wrap = racc_sum >= (WIDTH_W + 1)'(dst_width);

  // Copy one source bit into the destination byte that holds the current bit.
  always_comb begin
    merged = dst_q;
    merged[3'd7 - dpos[2:0]] = src_q[3'd7 - spos[2:0]];
  end

  assign hold_move = hold_valid && out_free;
  assign out_free  = !out_valid || result.ready;

  // Source step per destination cell: src_width / dst_width with remainder.
  pclr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sw_eff),
    .divisor  (dst_width),
    .res      (div_res)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and result capture.
  always_comb begin
    state_next           = state;
    req_ready            = 1'b0;
    hold_load            = 1'b0;
    hold_value.read_data = '0;
    hold_value.status    = STATUS_OK;
    div_start            = 1'b0;
    mul_a                = '0;
    src_we               = 1'b0;
    dst_we               = 1'b0;
    dst_waddr            = request.byte_address;
    dst_wdata            = request.byte_data;
    dst_raddr            = request.byte_address;
    src_raddr            = spos[LINE_BITS_W-1:3];
    unique case (state)
      ST_IDLE: begin
        req_ready = !hold_valid || hold_move;
        if (request.valid && req_ready) begin
          unique case (op_t'(request.operation))
            OP_LOAD_SRC: begin
              src_we    = 1'b1;
              hold_load = 1'b1;
            end
            OP_LOAD_DST: begin
              dst_we    = 1'b1;
              hold_load = 1'b1;
            end
            OP_RUN: begin
              if (bits_eff == '0) begin
                hold_load = 1'b1;
              end else begin
                state_next = ST_MUL_SRC;
              end
            end
            OP_READ_DST: state_next = ST_READ;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        hold_load            = 1'b1;
        hold_value.read_data = dst_q;
        state_next           = ST_IDLE;
      end
      ST_MUL_SRC: begin
        mul_a      = CELL_POS_W'(src_start) + CELL_POS_W'(sw_eff);
        state_next = ST_CMP_SRC;
      end
      ST_CMP_SRC: begin
        if (range_fail) begin
          hold_load         = 1'b1;
          hold_value.status = STATUS_SRC_RANGE;
          state_next        = ST_IDLE;
        end else begin
          state_next = ST_MUL_DST;
        end
      end
      ST_MUL_DST: begin
        mul_a      = CELL_POS_W'(dst_start) + CELL_POS_W'(dst_width);
        state_next = ST_CMP_DST;
      end
      ST_CMP_DST: begin
        if (range_fail) begin
          hold_load         = 1'b1;
          hold_value.status = STATUS_DST_RANGE;
          state_next        = ST_IDLE;
        end else if (dst_width == '0) begin
          hold_load  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        mul_a = CELL_POS_W'(dst_start);
        if (div_res.done) begin
          state_next = ST_CELL;
        end
      end
      ST_CELL: begin
        mul_a      = scell;
        state_next = ST_BIT_RD;
      end
      ST_BIT_RD: begin
        dst_raddr  = dpos[LINE_BITS_W-1:3];
        state_next = ST_BIT_WR;
      end
      ST_BIT_WR: begin
        dst_we    = 1'b1;
        dst_waddr = dpos[LINE_BITS_W-1:3];
        dst_wdata = merged;
        if (!bit_last) begin
          state_next = ST_BIT_RD;
        end else if (cell_last) begin
          hold_load  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_CELL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Run datapath: products, divider answer, cell walk and bit positions.
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL_SRC, ST_MUL_DST: begin
        prod <= mul_p;
      end
      ST_DIV: begin
        dpos <= mul_p[LINE_BITS_W-1:0];
        if (div_res.done) begin
          q_step   <= div_res.quotient;
          r_step   <= div_res.remainder;
          scell    <= CELL_POS_W'(src_start);
          racc     <= '0;
          cell_cnt <= '0;
        end
      end
      ST_CELL: begin
        spos    <= mul_p[LINE_BITS_W-1:0];
        bit_cnt <= '0;
      end
      ST_BIT_WR: begin
        spos    <= spos + 1'b1;
        dpos    <= dpos + 1'b1;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_last) begin
          cell_cnt <= cell_cnt + 1'b1;
          if (racc_wrap) begin
            racc  <= WIDTH_W'(racc_sum - (WIDTH_W + 1)'(dst_width));
            scell <= scell + CELL_POS_W'(q_step) + CELL_POS_W'(1);
          end else begin
            racc  <= racc_sum[WIDTH_W-1:0];
            scell <= scell + CELL_POS_W'(q_step);
          end
        end
      end
      default: ;
    endcase
  end

  // Line stores with registered read data.
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[request.byte_address] <= request.byte_data;
    end
    src_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (dst_we) begin
      dst_mem[dst_waddr] <= dst_wdata;
    end
    dst_q <= dst_mem[dst_raddr];
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (hold_load) begin
        hold_valid <= 1'b1;
      end else if (hold_move) begin
        hold_valid <= 1'b0;
      end
      if (hold_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result queue payload.
  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_data <= hold_value;
    end
    if (hold_move) begin
      out_data <= hold_data;
    end
  end

  assign request.ready    = req_ready;
  assign result.valid     = out_valid;
  assign result.read_data = out_data.read_data;
  assign result.status    = out_data.status;

endmodule
